[hdl/baa_pkg.sv]
// ----------------------------------------------------------------------------
// baa_pkg: shared types and constants for the bus access backoff arbiter
// Event codes, phase codes, outcome codes, state and result records.
// ----------------------------------------------------------------------------
package baa_pkg;

    localparam int unsigned OpW    = 2;
    localparam int unsigned AddrW  = 8;
    localparam int unsigned PrioW  = 4;
    localparam int unsigned TickW  = 8;
    localparam int unsigned LonW   = 3;
    localparam int unsigned BitNW  = 4;
    localparam int unsigned BackW  = 7;

    localparam logic [PrioW-1:0] PRIO_RESET    = 4'd6;
    localparam logic [PrioW-1:0] PRIO_LIMIT    = 4'd12;
    localparam logic [TickW-1:0] LISTEN_TICKS  = 8'd100;
    localparam logic [TickW-1:0] BIT_TICKS     = 8'd10;
    localparam logic [TickW-1:0] FIRST_SAMPLE  = 8'd3;
    localparam logic [BitNW-1:0] ARB_BITS      = 4'd11;
    localparam logic [BitNW-1:0] LAST_ADDR_BIT = 4'd8;
    localparam logic [LonW-1:0]  LONELY_RELOAD = 3'd6;
    localparam logic [8:0]       BACKOFF_MULT  = 9'd5;
    localparam logic [8:0]       BACKOFF_BASE  = 9'd22;

    typedef enum logic [OpW-1:0] {
        OP_START    = 2'd0,
        OP_TICK     = 2'd1,
        OP_ACTIVITY = 2'd2,
        OP_TX_DONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LISTEN  = 3'd1,
        PH_BACKOFF = 3'd2,
        PH_ARB     = 3'd3,
        PH_SEND    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        OC_BUSY = 2'd0,
        OC_WON  = 2'd1,
        OC_LOST = 2'd2,
        OC_IDLE = 2'd3
    } t_outcome;

    typedef struct packed {
        t_phase            phase;
        logic [TickW-1:0]  tick_count;
        logic [LonW-1:0]   loneliness;
        logic              activity_seen;
        logic [AddrW-1:0]  address_shift;
        logic [BitNW-1:0]  bit_number;
        logic [BackW-1:0]  backoff_length;
        logic              sticky_high;
    } t_state;

    typedef struct packed {
        logic [OpW-1:0]    operation;
        logic [AddrW-1:0]  source_address;
        logic              line_level;
    } t_item;

    typedef struct packed {
        logic              driver_enable;
        logic              hold_line_low;
        t_outcome          outcome;
    } t_result;

    // Level of the arbitration bit now on the wire: start bit, address LSB first, stop bits
    function automatic logic arb_bit(input logic [BitNW-1:0] bit_number,
                                     input logic [AddrW-1:0] address_shift);
        logic v;
        if (bit_number == '0) begin
            v = 1'b0;
        end else if (bit_number <= LAST_ADDR_BIT) begin
            v = address_shift[0];
        end else begin
            v = 1'b1;
        end
        return v;
    endfunction

endpackage

[hdl/baa_in_if.sv]
// ----------------------------------------------------------------------------
// baa_in_if: event channel
// Valid/ready channel carrying one arbiter event.
// ----------------------------------------------------------------------------
interface baa_in_if import baa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OpW-1:0]   operation;
    logic [AddrW-1:0] source_address;
    logic             line_level;

    modport source (output valid, operation, source_address, line_level, input ready);
    modport sink   (input valid, operation, source_address, line_level, output ready);
endinterface

[hdl/baa_out_if.sv]
// ----------------------------------------------------------------------------
// baa_out_if: result channel
// Valid/ready channel carrying one arbiter status result.
// ----------------------------------------------------------------------------
interface baa_out_if ();
    logic       valid;
    logic       ready;
    logic       driver_enable;
    logic       hold_line_low;
    logic [1:0] outcome;

    modport source (output valid, driver_enable, hold_line_low, outcome, input ready);
    modport sink   (input valid, driver_enable, hold_line_low, outcome, output ready);
endinterface

[hdl/baa_cfg_if.sv]
// ----------------------------------------------------------------------------
// baa_cfg_if: configuration write channel
// Valid/ready channel carrying the priority register write data.
// ----------------------------------------------------------------------------
interface baa_cfg_if import baa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PrioW-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hdl/baa_step.sv]
// ----------------------------------------------------------------------------
// baa_step: arbiter next-state and result logic
// Applies one event to the arbiter state and forms the status result.
// ----------------------------------------------------------------------------
module baa_step import baa_pkg::*; (
    input  t_state           i_state,
    input  t_item            i_item,
    input  logic [PrioW-1:0] i_prio,
    output t_state           o_state,
    output t_result          o_result
);

    t_state           n_state;
    logic             n_won;
    logic             n_lost;
    logic [TickW-1:0] tick_inc;
    logic [8:0]       backoff_sum;
    logic             cur_bit;
    logic             sticky;

    assign tick_inc    = i_state.tick_count + 8'd1;
    assign cur_bit     = arb_bit(i_state.bit_number, i_state.address_shift);
    assign sticky      = i_state.sticky_high | i_item.line_level;
    assign backoff_sum = ({6'd0, i_state.loneliness} + {5'd0, i_prio}) * BACKOFF_MULT
                       + {5'd0, i_item.source_address[3:0]} + BACKOFF_BASE;

    // next state
    always_comb begin
        n_state = i_state;
        n_won   = 1'b0;
        n_lost  = 1'b0;
        case (t_op'(i_item.operation))
            OP_START: begin
                if (i_state.phase == PH_IDLE) begin
                    n_state.address_shift  = i_item.source_address;
                    n_state.backoff_length = backoff_sum[BackW-1:0];
                    n_state.tick_count     = '0;
                    n_state.activity_seen  = 1'b0;
                    n_state.bit_number     = '0;
                    n_state.sticky_high    = 1'b0;
                    n_state.phase          = PH_LISTEN;
                end
            end
            OP_TICK: begin
                case (i_state.phase)
                    PH_LISTEN: begin
                        n_state.tick_count = tick_inc;
                        if (tick_inc >= LISTEN_TICKS) begin
                            if (i_state.activity_seen) begin
                                n_lost = 1'b1;
                            end else begin
                                n_state.phase      = PH_BACKOFF;
                                n_state.tick_count = '0;
                            end
                        end
                    end
                    PH_BACKOFF: begin
                        n_state.tick_count = tick_inc;
                        if (!i_item.line_level) begin
                            n_lost = 1'b1;
                        end else if (tick_inc >= {1'b0, i_state.backoff_length}) begin
                            n_state.phase       = PH_ARB;
                            n_state.tick_count  = '0;
                            n_state.bit_number  = '0;
                            n_state.sticky_high = 1'b0;
                        end
                    end
                    PH_ARB: begin
                        n_state.tick_count = tick_inc;
                        if (tick_inc >= FIRST_SAMPLE && tick_inc < BIT_TICKS) begin
                            // sticky sample: once high, stays high for this bit
                            n_state.sticky_high = sticky;
                            if (sticky != cur_bit) begin
                                n_lost = 1'b1;
                            end
                        end else if (tick_inc >= BIT_TICKS) begin
                            if (i_state.bit_number >= 4'd1 &&
                                i_state.bit_number <= LAST_ADDR_BIT) begin
                                n_state.address_shift = i_state.address_shift >> 1;
                            end
                            n_state.bit_number  = i_state.bit_number + 4'd1;
                            n_state.tick_count  = '0;
                            n_state.sticky_high = 1'b0;
                            if (n_state.bit_number >= ARB_BITS) begin
                                n_state.phase = PH_SEND;
                                n_won         = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_ACTIVITY: begin
                if (i_state.phase == PH_LISTEN) begin
                    n_state.activity_seen = 1'b1;
                end
            end
            OP_TX_DONE: begin
                n_state.loneliness = LONELY_RELOAD;
                if (i_state.phase == PH_SEND) begin
                    n_state.phase = PH_IDLE;
                end
            end
            default: begin
            end
        endcase
        if (n_lost) begin
            if (i_state.loneliness != '0) begin
                n_state.loneliness = i_state.loneliness - 3'd1;
            end
            n_state.phase       = PH_IDLE;
            n_state.tick_count  = '0;
            n_state.sticky_high = 1'b0;
        end
    end

    assign o_state = n_state;

    // outputs from the state after the event
    always_comb begin
        o_result.driver_enable = 1'b0;
        o_result.hold_line_low = 1'b0;
        o_result.outcome       = OC_BUSY;
        case (n_state.phase)
            PH_LISTEN: begin
            end
            PH_BACKOFF: begin
                o_result.hold_line_low = 1'b1;
            end
            PH_ARB: begin
                o_result.hold_line_low = 1'b1;
                o_result.driver_enable = ~arb_bit(n_state.bit_number, n_state.address_shift);
            end
            PH_SEND: begin
                o_result.driver_enable = 1'b1;
                o_result.outcome       = n_won ? OC_WON : OC_BUSY;
            end
            default: begin
                o_result.outcome = n_lost ? OC_LOST : OC_IDLE;
            end
        endcase
    end

endmodule

[hdl/bus_access_backoff_arbiter_core.sv]
// ----------------------------------------------------------------------------
// bus_access_backoff_arbiter_core: multi-drop bus access arbiter
// Listen, backoff and bitwise address arbitration driven by bus events.
// ----------------------------------------------------------------------------
// Each event on i_in (start request, 20us tick with line sample, receive
// activity, transmit complete) produces exactly one status transfer on o_out,
// in order. The block takes one event per clock while o_out is not stalled: an
// event waits in the input register, the arbiter state and status are updated
// from it in a single combinational step, and the status lands in the output
// register, so throughput is one transfer per cycle as long as o_out.ready is
// high. When o_out stalls, both stages hold and i_in.ready drops only once the
// input register is also full. Priority is written over i_cfg (always ready);
// values of 12 or more are dropped. The backoff length uses the priority in
// effect when the start request is processed.
// ----------------------------------------------------------------------------
module bus_access_backoff_arbiter_core import baa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    baa_in_if.sink    i_in,
    baa_out_if.source o_out,
    baa_cfg_if.sink   i_cfg
);

    // pipeline control
    logic             r_in_valid;
    t_item            r_in;
    logic             r_out_valid;
    t_result          r_out;
    logic             advance;

    // architectural state
    t_state           r_state;
    t_state           n_state;
    t_result          n_result;
    logic [PrioW-1:0] r_prio;

    // output stage frees up when empty or being drained
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    baa_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .i_prio   (r_prio),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.operation      <= i_in.operation;
            r_in.source_address <= i_in.source_address;
            r_in.line_level     <= i_in.line_level;
        end
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid            <= 1'b0;
            r_state.phase          <= PH_IDLE;
            r_state.tick_count     <= '0;
            r_state.loneliness     <= LONELY_RELOAD;
            r_state.activity_seen  <= 1'b0;
            r_state.address_shift  <= '0;
            r_state.bit_number     <= '0;
            r_state.backoff_length <= '0;
            r_state.sticky_high    <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= n_result;
        end
    end

    // priority register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= PRIO_RESET;
        end else if (i_cfg.valid && i_cfg.data < PRIO_LIMIT) begin
            r_prio <= i_cfg.data;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.driver_enable = r_out.driver_enable;
    assign o_out.hold_line_low = r_out.hold_line_low;
    assign o_out.outcome       = r_out.outcome;

endmodule
